>>> rtl/core/flkst_pkg.sv
// ---------------------------------------------------------------------------
// flkst_pkg
// Shared types, constants and helpers of the flock statistics core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package flkst_pkg;

   localparam int MAX_AGENTS_DEFAULT = 64;

   // Field widths of the transactions
   localparam int COORD_W  = 16;
   localparam int SAMPLE_W = 17;
   localparam int SPEED_W  = 16;
   localparam int TOTAL_W  = 7;

   localparam logic [SAMPLE_W-1:0] DIST_MAX  = 17'h1FFFF;
   localparam logic [SPEED_W-1:0]  SPEED_MAX = 16'hFFFF;

   // Sequencer states, one-hot
   typedef enum logic [14:0] {
      S_LOAD   = 15'b000000000000001,
      S_SETUP  = 15'b000000000000010,
      S_PASS   = 15'b000000000000100,
      S_RDA    = 15'b000000000001000,
      S_LATA   = 15'b000000000010000,
      S_LATB   = 15'b000000000100000,
      S_MULA   = 15'b000000001000000,
      S_MULB   = 15'b000000010000000,
      S_ROOT   = 15'b000000100000000,
      S_ACC    = 15'b000001000000000,
      S_DIVM   = 15'b000010000000000,
      S_DIVV   = 15'b000100000000000,
      S_ROOTV  = 15'b001000000000000,
      S_STORE  = 15'b010000000000000,
      S_FINISH = 15'b100000000000000
   } state_type;

   // Magnitude of the difference of two signed 16-bit values
   function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
      logic [SAMPLE_W-1:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      if (d[SAMPLE_W-1]) begin
         d = -d;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/flkst_if.sv
// ---------------------------------------------------------------------------
// flkst_if
// Valid/ready channels carrying agent transactions and result transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface flkst_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [15:0] vel_x;
   logic [15:0] vel_y;
   logic        last_agent;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, last_agent, input ready);
   modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, last_agent, output ready);
endinterface

interface flkst_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] mean_distance;
   logic [16:0] distance_deviation;
   logic [15:0] mean_speed;
   logic [15:0] speed_deviation;
   logic [6:0]  agent_total;

   modport source (output valid, mean_distance, distance_deviation, mean_speed,
                   speed_deviation, agent_total, input ready);
   modport sink   (input valid, mean_distance, distance_deviation, mean_speed,
                   speed_deviation, agent_total, output ready);
endinterface

`default_nettype wire

>>> rtl/core/flkst_ram.sv
// ---------------------------------------------------------------------------
// flkst_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flkst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/core/flkst_sqrt.sv
// ---------------------------------------------------------------------------
// flkst_sqrt
// Bit-serial integer square root, one root bit per cycle, floor result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flkst_sqrt #(
   parameter int IN_W = 36
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [IN_W-1:0]     operand,
   output      logic                done,
   output      logic [IN_W/2-1:0]   root
);

   localparam int RT_W  = IN_W / 2;
   localparam int REM_W = RT_W + 2;
   localparam int CW    = $clog2(RT_W + 1);

   logic [IN_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] rem_cat, trial;

   // One restoring step: bring down two radicand bits, try root*4+1
   always_comb begin
      rem_cat = {rem_ff[RT_W-1:0], rad_ff[IN_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(RT_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = rad_ff << 2;
         if (rem_cat >= trial) begin
            rem_in  = rem_cat - trial;
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_cat;
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

>>> rtl/core/flkst_div.sv
// ---------------------------------------------------------------------------
// flkst_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flkst_div #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output      logic             done,
   output      logic [NUM_W-1:0] quotient
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_cat;

   // Shift in one numerator bit, subtract the divisor when it fits
   always_comb begin
      rem_cat = {rem_ff, quo_ff[NUM_W-1]};
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = numer;
         den_in = denom;
         rem_in = '0;
         cnt_in = CW'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_cat >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_cat - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_cat[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/flock_statistics_core.sv
// ---------------------------------------------------------------------------
// flock_statistics_core
// Pairwise distance and speed statistics over one loaded set of agents.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one agent per transaction (position Q11.5, velocity
//   Q8.8, last_agent flag). Agents are stored in two RAMs until a transaction
//   with last_agent set arrives; agents beyond MAX_AGENTS are dropped.
//   After the last agent the core computes and sends one rsp_chan transaction
//   holding mean and sample deviation of pair distances and of speeds, and
//   the agent total. The store is then empty for the next set.
// Phases:
//   Loading accepts an agent whenever req_chan is valid. The compute phase
//   makes two passes over the N(N-1)/2 pairs and two passes over the N
//   agents; each sample takes a root in the bit-serial square-root unit
//   (RT_W = 23 for 64 agents), and the passes add at most four divides and
//   two roots. req_chan is not ready during the compute phase.
// Reset and stalls:
//   Synchronous reset empties the store and drops any pending result. A
//   finished result waits in the output register while the next set loads;
//   the core stalls only if a further result is ready before it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flock_statistics_core #(
   parameter int MAX_AGENTS = flkst_pkg::MAX_AGENTS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   flkst_req_if.sink       req_chan,
   flkst_rsp_if.source     rsp_chan
);

   localparam int SW     = flkst_pkg::SAMPLE_W;
   localparam int AW     = $clog2(MAX_AGENTS);
   localparam int CNT_W  = $clog2(MAX_AGENTS + 1);
   localparam int PRW    = $clog2(MAX_AGENTS * (MAX_AGENTS - 1) / 2 + 1);
   localparam int PAIR_W = (PRW > CNT_W) ? PRW : CNT_W;
   localparam int ACC_W  = PAIR_W + 2 * SW;
   localparam int SQ_W   = ACC_W + (ACC_W % 2);
   localparam int RT_W   = SQ_W / 2;
   localparam int DW     = 2 * flkst_pkg::COORD_W;

   flkst_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [PAIR_W-1:0] pairs_ff, pairs_in;
   logic              speed_mode_ff, speed_mode_in;
   logic              pass_ff, pass_in;
   logic [SW-1:0]     pi_x_ff, pi_x_in, pi_y_ff, pi_y_in;
   logic [SW-1:0]     da_ff, da_in, db_ff, db_in;
   logic [2*SW:0]     sq_ff, sq_in;
   logic [SW-1:0]     sample_ff, sample_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [SW-1:0]     mean_ff, mean_in;
   logic [SW-1:0]     dev_ff, dev_in;

   logic [SW-1:0]  res_mean_d_ff, res_mean_d_in, res_dev_d_ff, res_dev_d_in;
   logic [15:0]    res_mean_s_ff, res_mean_s_in, res_dev_s_ff, res_dev_s_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]  out_mean_d_ff, out_mean_d_in, out_dev_d_ff, out_dev_d_in;
   logic [15:0]    out_mean_s_ff, out_mean_s_in, out_dev_s_ff, out_dev_s_in;
   logic [6:0]     out_total_ff, out_total_in;

   logic              wr_en;
   logic [AW-1:0]     rd_addr;
   logic [DW-1:0]     pos_rd, vel_rd;
   logic [SW-1:0]     mul_a, mul_b;
   logic [2*SW-1:0]   product;
   logic [PAIR_W-1:0] samples;
   logic [SW-1:0]     off;

   logic              sqrt_start, sqrt_done;
   logic [SQ_W-1:0]   sqrt_arg;
   logic [RT_W-1:0]   sqrt_root;
   logic              div_start, div_done;
   logic [ACC_W-1:0]  div_num, div_quo;
   logic [PAIR_W-1:0] div_den;

   // Agent store: position and velocity pairs
   assign wr_en   = req_chan.valid && req_chan.ready && (cnt_ff < CNT_W'(MAX_AGENTS));
   assign rd_addr = (state_ff == flkst_pkg::S_LATA) ? j_ff[AW-1:0] : i_ff[AW-1:0];

   flkst_ram #(.WIDTH(DW), .DEPTH(MAX_AGENTS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data ({req_chan.pos_x, req_chan.pos_y}),
      .rd_addr (rd_addr),
      .rd_data (pos_rd)
   );

   flkst_ram #(.WIDTH(DW), .DEPTH(MAX_AGENTS)) u_vel_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data ({req_chan.vel_x, req_chan.vel_y}),
      .rd_addr (rd_addr),
      .rd_data (vel_rd)
   );

   flkst_sqrt #(.IN_W(SQ_W)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sqrt_arg),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   flkst_div #(.NUM_W(ACC_W), .DEN_W(PAIR_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Shared multiplier operand select
   assign off = (sample_ff >= mean_ff) ? (sample_ff - mean_ff) : (mean_ff - sample_ff);

   always_comb begin
      case (state_ff)
         flkst_pkg::S_SETUP: begin
            mul_a = SW'(n_ff);
            mul_b = SW'(n_ff - 1'b1);
         end
         flkst_pkg::S_MULA: begin
            mul_a = da_ff;
            mul_b = da_ff;
         end
         flkst_pkg::S_MULB: begin
            mul_a = db_ff;
            mul_b = db_ff;
         end
         default: begin
            mul_a = off;
            mul_b = off;
         end
      endcase
   end

   assign product = mul_a * mul_b;
   assign samples = speed_mode_ff ? PAIR_W'(n_ff) : pairs_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pairs_in      = pairs_ff;
      speed_mode_in = speed_mode_ff;
      pass_in       = pass_ff;
      pi_x_in       = pi_x_ff;
      pi_y_in       = pi_y_ff;
      da_in         = da_ff;
      db_in         = db_ff;
      sq_in         = sq_ff;
      sample_in     = sample_ff;
      acc_in        = acc_ff;
      mean_in       = mean_ff;
      dev_in        = dev_ff;
      res_mean_d_in = res_mean_d_ff;
      res_dev_d_in  = res_dev_d_ff;
      res_mean_s_in = res_mean_s_ff;
      res_dev_s_in  = res_dev_s_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_mean_d_in = out_mean_d_ff;
      out_dev_d_in  = out_dev_d_ff;
      out_mean_s_in = out_mean_s_ff;
      out_dev_s_in  = out_dev_s_ff;
      out_total_in  = out_total_ff;
      sqrt_start    = 1'b0;
      sqrt_arg      = SQ_W'(sq_ff);
      div_start     = 1'b0;
      div_num       = acc_ff;
      div_den       = samples;
      req_chan.ready = (state_ff == flkst_pkg::S_LOAD);

      case (state_ff)
         flkst_pkg::S_LOAD: begin
            // Store agents; the last one closes the set
            if (req_chan.valid) begin
               if (wr_en) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_chan.last_agent) begin
                  n_in          = cnt_in;
                  cnt_in        = '0;
                  speed_mode_in = 1'b0;
                  state_in      = flkst_pkg::S_SETUP;
               end
            end
         end
         flkst_pkg::S_SETUP: begin
            pairs_in = PAIR_W'(product >> 1);
            state_in = flkst_pkg::S_PASS;
         end
         flkst_pkg::S_PASS: begin
            // Start the mean pass, or settle zeros when nothing to average
            i_in    = '0;
            j_in    = CNT_W'(1);
            pass_in = 1'b0;
            acc_in  = '0;
            if (samples == '0) begin
               mean_in  = '0;
               dev_in   = '0;
               state_in = flkst_pkg::S_STORE;
            end else begin
               state_in = flkst_pkg::S_RDA;
            end
         end
         flkst_pkg::S_RDA: begin
            state_in = flkst_pkg::S_LATA;
         end
         flkst_pkg::S_LATA: begin
            if (speed_mode_ff) begin
               da_in    = flkst_pkg::abs_diff(vel_rd[DW-1 -: 16], '0);
               db_in    = flkst_pkg::abs_diff(vel_rd[15:0], '0);
               state_in = flkst_pkg::S_MULA;
            end else begin
               pi_x_in  = SW'(pos_rd[DW-1 -: 16]);
               pi_y_in  = SW'(pos_rd[15:0]);
               state_in = flkst_pkg::S_LATB;
            end
         end
         flkst_pkg::S_LATB: begin
            da_in    = flkst_pkg::abs_diff(pi_x_ff[15:0], pos_rd[DW-1 -: 16]);
            db_in    = flkst_pkg::abs_diff(pi_y_ff[15:0], pos_rd[15:0]);
            state_in = flkst_pkg::S_MULA;
         end
         flkst_pkg::S_MULA: begin
            sq_in    = {1'b0, product};
            state_in = flkst_pkg::S_MULB;
         end
         flkst_pkg::S_MULB: begin
            sqrt_arg   = SQ_W'(sq_ff + {1'b0, product});
            sqrt_start = 1'b1;
            state_in   = flkst_pkg::S_ROOT;
         end
         flkst_pkg::S_ROOT: begin
            if (sqrt_done) begin
               sample_in = sqrt_root[SW-1:0];
               state_in  = flkst_pkg::S_ACC;
            end
         end
         flkst_pkg::S_ACC: begin
            // Sum sample or squared offset, then go to the next pair or agent
            if (pass_ff) begin
               acc_in = acc_ff + ACC_W'(product);
            end else begin
               acc_in = acc_ff + ACC_W'(sample_ff);
            end
            state_in = flkst_pkg::S_RDA;
            if (speed_mode_ff) begin
               i_in = i_ff + 1'b1;
               if (i_in == n_ff) begin
                  state_in = flkst_pkg::S_DIVM;
               end
            end else if (j_ff == n_ff - 1'b1) begin
               i_in = i_ff + 1'b1;
               j_in = i_ff + CNT_W'(2);
               if (i_in == n_ff - 1'b1) begin
                  state_in = flkst_pkg::S_DIVM;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (state_in == flkst_pkg::S_DIVM) begin
               if (!pass_ff) begin
                  div_num   = acc_in + ACC_W'(samples >> 1);
                  div_start = 1'b1;
               end else if (samples < PAIR_W'(2)) begin
                  dev_in   = '0;
                  state_in = flkst_pkg::S_STORE;
               end else begin
                  div_num   = acc_in;
                  div_den   = samples - 1'b1;
                  div_start = 1'b1;
                  state_in  = flkst_pkg::S_DIVV;
               end
            end
         end
         flkst_pkg::S_DIVM: begin
            // Rounded mean ready: begin the deviation pass
            if (div_done) begin
               mean_in  = (div_quo > ACC_W'(flkst_pkg::DIST_MAX)) ?
                          flkst_pkg::DIST_MAX : div_quo[SW-1:0];
               pass_in  = 1'b1;
               acc_in   = '0;
               i_in     = '0;
               j_in     = CNT_W'(1);
               state_in = flkst_pkg::S_RDA;
            end
         end
         flkst_pkg::S_DIVV: begin
            if (div_done) begin
               sqrt_arg   = SQ_W'(div_quo);
               sqrt_start = 1'b1;
               state_in   = flkst_pkg::S_ROOTV;
            end
         end
         flkst_pkg::S_ROOTV: begin
            if (sqrt_done) begin
               dev_in   = (sqrt_root > RT_W'(flkst_pkg::DIST_MAX)) ?
                          flkst_pkg::DIST_MAX : sqrt_root[SW-1:0];
               state_in = flkst_pkg::S_STORE;
            end
         end
         flkst_pkg::S_STORE: begin
            // Keep this group's figures, then move on to speeds or finish
            if (speed_mode_ff) begin
               res_mean_s_in = (mean_ff > SW'(flkst_pkg::SPEED_MAX)) ?
                               flkst_pkg::SPEED_MAX : mean_ff[15:0];
               res_dev_s_in  = (dev_ff > SW'(flkst_pkg::SPEED_MAX)) ?
                               flkst_pkg::SPEED_MAX : dev_ff[15:0];
               state_in      = flkst_pkg::S_FINISH;
            end else begin
               res_mean_d_in = mean_ff;
               res_dev_d_in  = dev_ff;
               speed_mode_in = 1'b1;
               state_in      = flkst_pkg::S_PASS;
            end
         end
         flkst_pkg::S_FINISH: begin
            // Hand over to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_mean_d_in = res_mean_d_ff;
               out_dev_d_in  = res_dev_d_ff;
               out_mean_s_in = res_mean_s_ff;
               out_dev_s_in  = res_dev_s_ff;
               out_total_in  = flkst_pkg::TOTAL_W'(n_ff);
               rsp_valid_in  = 1'b1;
               state_in      = flkst_pkg::S_LOAD;
            end
         end
         default: begin
            state_in = flkst_pkg::S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flkst_pkg::S_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      pairs_ff      <= pairs_in;
      speed_mode_ff <= speed_mode_in;
      pass_ff       <= pass_in;
      pi_x_ff       <= pi_x_in;
      pi_y_ff       <= pi_y_in;
      da_ff         <= da_in;
      db_ff         <= db_in;
      sq_ff         <= sq_in;
      sample_ff     <= sample_in;
      acc_ff        <= acc_in;
      mean_ff       <= mean_in;
      dev_ff        <= dev_in;
      res_mean_d_ff <= res_mean_d_in;
      res_dev_d_ff  <= res_dev_d_in;
      res_mean_s_ff <= res_mean_s_in;
      res_dev_s_ff  <= res_dev_s_in;
      out_mean_d_ff <= out_mean_d_in;
      out_dev_d_ff  <= out_dev_d_in;
      out_mean_s_ff <= out_mean_s_in;
      out_dev_s_ff  <= out_dev_s_in;
      out_total_ff  <= out_total_in;
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.mean_distance      = out_mean_d_ff;
   assign rsp_chan.distance_deviation = out_dev_d_ff;
   assign rsp_chan.mean_speed         = out_mean_s_ff;
   assign rsp_chan.speed_deviation    = out_dev_s_ff;
   assign rsp_chan.agent_total        = out_total_ff;

   // Checks on the sequencer and the shared units
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_AGENTS))
      else $error("agent count beyond store depth");

   a_sqrt_owner: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == flkst_pkg::S_ROOT || state_ff == flkst_pkg::S_ROOTV))
      else $error("root finished outside a root wait");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == flkst_pkg::S_DIVM || state_ff == flkst_pkg::S_DIVV))
      else $error("divide finished outside a divide wait");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flkst_pkg::S_FINISH && state_in == flkst_pkg::S_LOAD) |=> rsp_valid_ff)
      else $error("result not presented after compute");

endmodule

`default_nettype wire

>>> verif/flock_statistics_core_tb.sv
// ---------------------------------------------------------------------------
// flock_statistics_core_tb
// Self-checking bench for the flock statistics core: agent sets are streamed
// in over the request channel, a local model (or a typed row) predicts the
// distance and speed statistics of each set, and each response is compared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module flock_statistics_core_tb;

   localparam int MAX_SET     = flkst_pkg::MAX_AGENTS_DEFAULT;
   localparam int ITEM_TARGET = 400;
   localparam int HOLD_CYCLES = 3000;

   typedef struct packed {
      logic [flkst_pkg::SAMPLE_W-1:0] mean_distance;
      logic [flkst_pkg::SAMPLE_W-1:0] distance_deviation;
      logic [flkst_pkg::SPEED_W-1:0]  mean_speed;
      logic [flkst_pkg::SPEED_W-1:0]  speed_deviation;
      logic [flkst_pkg::TOTAL_W-1:0]  agent_total;
   } flock_stats_type;

   typedef struct {
      logic [flkst_pkg::COORD_W-1:0] pos_x;
      logic [flkst_pkg::COORD_W-1:0] pos_y;
      logic [flkst_pkg::COORD_W-1:0] vel_x;
      logic [flkst_pkg::COORD_W-1:0] vel_y;
      logic                          last_agent;
      logic                          typed;
      flock_stats_type               stats;
   } agent_row_type;

   logic clock;
   logic reset;

   flkst_req_if req_chan ();
   flkst_rsp_if rsp_chan ();

   flock_statistics_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Local copy of the agent store
   logic signed [flkst_pkg::COORD_W-1:0] set_px [MAX_SET];
   logic signed [flkst_pkg::COORD_W-1:0] set_py [MAX_SET];
   logic signed [flkst_pkg::COORD_W-1:0] set_vx [MAX_SET];
   logic signed [flkst_pkg::COORD_W-1:0] set_vy [MAX_SET];
   int                                   set_count;

   flock_stats_type pending_stats [$];
   int              error_count;
   int              sender_idle_pct;
   int              receiver_stall_pct;
   bit              hold_request;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= root + bit_w) begin
            v    = v - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned magnitude(input longint a, input longint b);
      longint unsigned ua;
      longint unsigned ub;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      return floor_root(ua * ua + ub * ub);
   endfunction

   function automatic longint unsigned round_mean(input longint unsigned total,
                                                 input longint unsigned n);
      return (n == 0) ? 0 : (total + n / 2) / n;
   endfunction

   function automatic longint unsigned sample_dev(input longint unsigned sq,
                                                  input longint unsigned n);
      return (n < 2) ? 0 : floor_root(sq / (n - 1));
   endfunction

   function automatic longint unsigned sq_offset(input longint unsigned s,
                                                 input longint unsigned m);
      longint unsigned d;
      d = (s >= m) ? s - m : m - s;
      return d * d;
   endfunction

   function automatic longint unsigned clip(input longint unsigned v,
                                            input longint unsigned lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic longint unsigned pair_dist(input int i, input int j);
      return magnitude(longint'(set_px[i]) - longint'(set_px[j]),
                       longint'(set_py[i]) - longint'(set_py[j]));
   endfunction

   // Store one agent; on the last agent compute the set statistics
   function automatic bit flock_predict(input logic [flkst_pkg::COORD_W-1:0] px,
                                        input logic [flkst_pkg::COORD_W-1:0] py,
                                        input logic [flkst_pkg::COORD_W-1:0] vx,
                                        input logic [flkst_pkg::COORD_W-1:0] vy,
                                        input logic last_agent,
                                        output flock_stats_type stats);
      longint unsigned pairs;
      longint unsigned total;
      longint unsigned sq;
      longint unsigned mean_d;
      longint unsigned mean_s;
      int n;
      stats = '0;
      if (set_count < MAX_SET) begin
         set_px[set_count] = px;
         set_py[set_count] = py;
         set_vx[set_count] = vx;
         set_vy[set_count] = vy;
         set_count++;
      end
      if (!last_agent) return 1'b0;
      n     = set_count;
      pairs = (n > 0) ? longint'(n) * (n - 1) / 2 : 0;
      total = 0;
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++) total += pair_dist(i, j);
      mean_d = round_mean(total, pairs);
      sq = 0;
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++) sq += sq_offset(pair_dist(i, j), mean_d);
      stats.mean_distance      = flkst_pkg::SAMPLE_W'(clip(mean_d, flkst_pkg::DIST_MAX));
      stats.distance_deviation =
         flkst_pkg::SAMPLE_W'(clip(sample_dev(sq, pairs), flkst_pkg::DIST_MAX));
      total = 0;
      for (int i = 0; i < n; i++) total += magnitude(set_vx[i], set_vy[i]);
      mean_s = round_mean(total, n);
      sq = 0;
      for (int i = 0; i < n; i++) sq += sq_offset(magnitude(set_vx[i], set_vy[i]), mean_s);
      stats.mean_speed      = flkst_pkg::SPEED_W'(clip(mean_s, flkst_pkg::SPEED_MAX));
      stats.speed_deviation =
         flkst_pkg::SPEED_W'(clip(sample_dev(sq, n), flkst_pkg::SPEED_MAX));
      stats.agent_total     = n[flkst_pkg::TOTAL_W-1:0];
      set_count = 0;
      return 1'b1;
   endfunction

   // Offer one agent, hold it until accepted, then queue any expected result
   task automatic send_agent(input agent_row_type row);
      flock_stats_type stats;
      int gap;
      gap = 0;
      while ($urandom_range(99, 0) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.pos_x      <= row.pos_x;
      req_chan.pos_y      <= row.pos_y;
      req_chan.vel_x      <= row.vel_x;
      req_chan.vel_y      <= row.vel_y;
      req_chan.last_agent <= row.last_agent;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (flock_predict(row.pos_x, row.pos_y, row.vel_x, row.vel_y, row.last_agent,
                        stats)) begin
         if (row.typed) stats = row.stats;
         pending_stats = {pending_stats, stats};
      end
      @(negedge clock);
   endtask

   function automatic logic [flkst_pkg::COORD_W-1:0] random_coord(input int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'($urandom_range(64, 0) - 32);
         default: return {$urandom_range(1, 0) ? 2'b11 : 2'b00, 14'($urandom)};
      endcase
   endfunction

   // Receiver ready, with a long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
            @(negedge clock);
         end
      end
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      flock_stats_type seen;
      flock_stats_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.mean_distance, rsp_chan.distance_deviation,
                  rsp_chan.mean_speed, rsp_chan.speed_deviation, rsp_chan.agent_total};
         if (pending_stats.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result %p", seen);
         end else begin
            want = pending_stats.pop_front();
            if (seen.mean_distance !== want.mean_distance ||
                seen.distance_deviation !== want.distance_deviation ||
                seen.mean_speed !== want.mean_speed ||
                seen.speed_deviation !== want.speed_deviation ||
                seen.agent_total !== want.agent_total) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected %p actual %p", want, seen);
            end
         end
      end
   end

   // Stimulus
   initial begin
      agent_row_type directed [12];
      agent_row_type row;
      int sent;
      int set_size;
      int style;
      int big_sets;
      int wait_cycles;

      directed = '{
         '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{0, 0, 0, 0, 1}},
         '{16'h0000, 16'h0000, 16'h8000, 16'h8000, 1'b1, 1'b1, '{0, 0, 46340, 0, 1}},
         '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b1, 1'b1, '{0, 0, 32767, 0, 1}},
         '{16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, 1'b0, '0},
         '{16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
         '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 1'b0, 1'b0, '0},
         '{16'h7FFF, 16'h8000, 16'h0100, 16'hFF00, 1'b0, 1'b0, '0},
         '{16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, '0},
         '{16'h0020, 16'hFFE0, 16'h0180, 16'h0000, 1'b0, 1'b0, '0},
         '{16'h0020, 16'hFFE0, 16'h0180, 16'h0000, 1'b0, 1'b0, '0},
         '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0, '0},
         '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0, '0}
      };

      error_count        = 0;
      set_count          = 0;
      hold_request       = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      req_chan.valid      = 1'b0;
      req_chan.pos_x      = '0;
      req_chan.pos_y      = '0;
      req_chan.vel_x      = '0;
      req_chan.vel_y      = '0;
      req_chan.last_agent = 1'b0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows
      foreach (directed[k]) send_agent(directed[k]);

      // Random sets through four idling phases
      sent     = 0;
      big_sets = 0;
      row.typed = 1'b0;
      row.stats = '0;
      while (sent < ITEM_TARGET) begin
         case (sent * 4 / ITEM_TARGET)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
         endcase
         if (sent * 4 / ITEM_TARGET == 2 && sent % 100 < 10) hold_request = 1'b1;
         // Mostly small sets; one full and one overfull set
         if (big_sets < 2 && sent > ITEM_TARGET / 3 * (big_sets + 1)) begin
            set_size = (big_sets == 0) ? MAX_SET : MAX_SET + 6;
            big_sets++;
         end else if ($urandom_range(9, 0) == 0) begin
            set_size = $urandom_range(20, 2);
         end else begin
            set_size = $urandom_range(8, 1);
         end
         style = $urandom_range(2, 0);
         for (int a = 0; a < set_size; a++) begin
            row.pos_x      = random_coord(style);
            row.pos_y      = random_coord(style);
            row.vel_x      = random_coord($urandom_range(2, 0));
            row.vel_y      = random_coord($urandom_range(2, 0));
            row.last_agent = (a == set_size - 1);
            send_agent(row);
            sent++;
         end
      end
      req_chan.valid <= 1'b0;

      // Drain
      wait_cycles = 0;
      while (pending_stats.size() != 0 && wait_cycles < 2000000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_stats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Run limit
   initial begin
      #80_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/flkst_pkg.sv
rtl/core/flkst_if.sv
rtl/core/flkst_ram.sv
rtl/core/flkst_sqrt.sv
rtl/core/flkst_div.sv
rtl/core/flock_statistics_core.sv
verif/flock_statistics_core_tb.sv
